### hdl/mutex_lock_unit_with_handoff_defines.svh
// Assertion macros of the mutex lock unit, used by the table engine.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MUTEX_LOCK_UNIT_WITH_HANDOFF_DEFINES_SVH
`define MUTEX_LOCK_UNIT_WITH_HANDOFF_DEFINES_SVH

// same-cycle implication
`define MLU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MLU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mlu_pkg.sv
// Types and constants of the mutex lock unit.
// No dependencies; imported by every module of the block except mlu_ram.
`timescale 1ns / 1ps
`default_nettype none

package mlu_pkg;

   localparam int MODE_W   = 2;
   localparam int LOCK_W   = 4;
   localparam int THREAD_W = 4;
   localparam int STATUS_W = 4;

   typedef enum logic [MODE_W-1:0] {
      OP_LOCK    = 2'd0,
      OP_UNLOCK  = 2'd1,
      OP_TRY     = 2'd2,
      OP_DESTROY = 2'd3
   } op_type;

   localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_REENTERED = 4'd1;
   localparam logic [STATUS_W-1:0] ST_BLOCKED   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 4'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_HANDOFF   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_TRY_FAIL  = 4'd6;
   localparam logic [STATUS_W-1:0] ST_DESTROYED = 4'd7;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 4'd8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DEQ
   } back_state_type;

   typedef struct packed {
      logic                last;
      logic [THREAD_W-1:0] woken_thread;
      logic                woken_valid;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/mutex_lock_unit_with_handoff.sv
// Top level of the mutex lock unit: request front end, command queue, table engine.
// Depends on mlu_pkg, mlu_front, mlu_cmdq, mlu_back.
//
//   channel  beat fields                                     end
//   req_     tuser: mode; tdata: lock_index, thread_id       slave
//   rsp_     tdata: status, woken_valid, woken_thread; tlast master
//
// A request in the table engine does one lock-table read, then one update.
// Unlock with a waiter adds a dequeue step; destroy adds one per woken waiter.
// The two-entry command queue lets requests land while the engine works.
// A stalled result holds the engine; requests still enter until the queue fills.
// Reset is synchronous; every lock comes out free with no waiters, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mutex_lock_unit_with_handoff
   import mlu_pkg::*;
#(
   parameter int NUM_LOCKS   = 16,
   parameter int NUM_THREADS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // lock_index[3:0], thread_id[7:4]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // status[3:0], woken_valid[4], woken_thread[8:5], zero
   output logic             rsp_tlast
);

   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int TW = $clog2(NUM_THREADS);
   localparam int CW = MODE_W + LW + TW;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   op_type        f_op;
   logic [LW-1:0] f_lock;
   logic [TW-1:0] f_thread;
   logic [CW-1:0] push_data, pop_data;
   rsp_type       rsp;

   mlu_front #(.NUM_LOCKS(NUM_LOCKS), .NUM_THREADS(NUM_THREADS)) u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_lock   (req_tdata[3:0]),
      .req_thread (req_tdata[7:4]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .cmd_op     (f_op),
      .cmd_lock   (f_lock),
      .cmd_thread (f_thread)
   );

   assign push_data = {f_op, f_lock, f_thread};

   mlu_cmdq #(.WIDTH(CW)) u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mlu_back #(.NUM_LOCKS(NUM_LOCKS), .NUM_THREADS(NUM_THREADS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd_op     (op_type'(pop_data[CW-1:LW+TW])),
      .cmd_lock   (pop_data[LW+TW-1:TW]),
      .cmd_thread (pop_data[TW-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'b0, rsp.woken_thread, rsp.woken_valid, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

### hdl/mlu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; used for the per-lock and per-thread tables.
`timescale 1ns / 1ps
`default_nettype none

module mlu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/mlu_front.sv
// Request front end: takes request beats, folds indices into range, decodes the mode.
// Depends on mlu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlu_front
   import mlu_pkg::*;
#(
   parameter int NUM_LOCKS   = 16,
   parameter int NUM_THREADS = 16,
   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
   localparam int TW = $clog2(NUM_THREADS)
) (
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [LOCK_W-1:0]   req_lock,
   input  wire logic [THREAD_W-1:0] req_thread,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output op_type                   cmd_op,
   output logic      [LW-1:0]       cmd_lock,
   output logic      [TW-1:0]       cmd_thread
);

   always_comb begin
      cmd_lock   = '0;
      cmd_thread = '0;
      for (int i = 0; i < (1 << LOCK_W); i++) begin
         if (req_lock == LOCK_W'(i)) begin
            cmd_lock = LW'(i % NUM_LOCKS);
         end
      end
      for (int j = 0; j < (1 << THREAD_W); j++) begin
         if (req_thread == THREAD_W'(j)) begin
            cmd_thread = TW'(j % NUM_THREADS);
         end
      end
   end

   assign cmd_op     = op_type'(req_mode);
   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

### hdl/mlu_cmdq.sv
// Two-entry command queue between the front end and the table engine.
// Depends on mlu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlu_cmdq
   import mlu_pkg::*;
#(
   parameter int WIDTH = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = data_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/mlu_back.sv
// Table engine: owner and queue tables, lock sequencer, waiter walk, result register.
// Depends on mlu_pkg, mlu_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mutex_lock_unit_with_handoff_defines.svh"

module mlu_back
   import mlu_pkg::*;
#(
   parameter int NUM_LOCKS   = 16,
   parameter int NUM_THREADS = 16,
   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
   localparam int TW = $clog2(NUM_THREADS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  wire op_type        cmd_op,
   input  wire logic [LW-1:0] cmd_lock,
   input  wire logic [TW-1:0] cmd_thread,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp
);

   localparam int WW = 3 * TW;

   back_state_type state_ff, state_in;
   op_type         cmd_op_ff;
   logic [LW-1:0]  cmd_l_ff;
   logic [TW-1:0]  cmd_t_ff;
   logic [TW-1:0]  first_ff, first_in;
   logic [TW-1:0]  last_ff;
   logic           first_we, load_fl;

   logic           held_ff    [NUM_LOCKS];
   logic           ne_ff      [NUM_LOCKS];
   logic           waiting_ff [NUM_THREADS];
   logic           held_we, held_in, ne_we, ne_in, ws_en, wc_en;

   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   logic           emit;
   rsp_type        emit_rsp;
   logic           out_free;

   logic           lk_rd_en, lk_wr_en;
   logic [LW-1:0]  lk_rd_addr;
   logic [WW-1:0]  lk_wr_data, lk_rd_data;
   logic           nw_rd_en, nw_wr_en;
   logic [TW-1:0]  nw_rd_addr, nw_wr_addr, nw_wr_data, nw_rd_data;

   logic [TW-1:0]  w_owner, w_first, w_last;
   logic           held, ne, tw, done;

   mlu_ram #(.WIDTH(WW), .DEPTH(NUM_LOCKS)) u_lock_ram (
      .clock   (clock),
      .wr_en   (lk_wr_en),
      .wr_addr (cmd_l_ff),
      .wr_data (lk_wr_data),
      .rd_en   (lk_rd_en),
      .rd_addr (lk_rd_addr),
      .rd_data (lk_rd_data)
   );

   mlu_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nw_wr_en),
      .wr_addr (nw_wr_addr),
      .wr_data (nw_wr_data),
      .rd_en   (nw_rd_en),
      .rd_addr (nw_rd_addr),
      .rd_data (nw_rd_data)
   );

   assign w_owner  = lk_rd_data[3*TW-1:2*TW];
   assign w_first  = lk_rd_data[2*TW-1:TW];
   assign w_last   = lk_rd_data[TW-1:0];
   assign held     = held_ff[cmd_l_ff];
   assign ne       = ne_ff[cmd_l_ff];
   assign tw       = waiting_ff[cmd_t_ff];
   assign done     = (first_ff == last_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd_ready  = 1'b0;
      lk_rd_en   = 1'b0;
      lk_rd_addr = cmd_lock;
      lk_wr_en   = 1'b0;
      lk_wr_data = {w_owner, w_first, w_last};
      nw_rd_en   = 1'b0;
      nw_rd_addr = w_first;
      nw_wr_en   = 1'b0;
      nw_wr_addr = w_last;
      nw_wr_data = cmd_t_ff;
      emit       = 1'b0;
      emit_rsp   = '0;
      held_we    = 1'b0;
      held_in    = 1'b0;
      ne_we      = 1'b0;
      ne_in      = 1'b0;
      ws_en      = 1'b0;
      wc_en      = 1'b0;
      first_we   = 1'b0;
      first_in   = nw_rd_data;
      load_fl    = 1'b0;
      emit_rsp.last = 1'b1;
      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               lk_rd_en = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            nw_rd_en = 1'b1;
            load_fl  = 1'b1;
            case (cmd_op_ff)
               OP_LOCK, OP_TRY: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (tw) begin
                        emit_rsp.status = ST_BUSY;
                     end else if (!held) begin
                        emit_rsp.status = ST_ACQUIRED;
                        held_we    = 1'b1;
                        held_in    = 1'b1;
                        lk_wr_en   = 1'b1;
                        lk_wr_data = {cmd_t_ff, w_first, w_last};
                     end else if (cmd_op_ff == OP_TRY) begin
                        emit_rsp.status = ST_TRY_FAIL;
                     end else if (w_owner == cmd_t_ff) begin
                        emit_rsp.status = ST_REENTERED;
                     end else begin
                        emit_rsp.status = ST_BLOCKED;
                        ws_en    = 1'b1;
                        lk_wr_en = 1'b1;
                        if (ne) begin
                           nw_wr_en   = 1'b1;
                           lk_wr_data = {w_owner, w_first, cmd_t_ff};
                        end else begin
                           lk_wr_data = {w_owner, cmd_t_ff, cmd_t_ff};
                           ne_we      = 1'b1;
                           ne_in      = 1'b1;
                        end
                     end
                  end
               end
               OP_UNLOCK: begin
                  if (!held || (w_owner != cmd_t_ff)) begin
                     if (out_free) begin
                        emit            = 1'b1;
                        emit_rsp.status = ST_NOT_OWNER;
                        state_in        = S_IDLE;
                     end
                  end else if (ne) begin
                     state_in = S_DEQ;
                  end else if (out_free) begin
                     emit            = 1'b1;
                     emit_rsp.status = ST_RELEASED;
                     held_we         = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               OP_DESTROY: begin
                  if (ne) begin
                     state_in = S_DEQ;
                  end else if (out_free) begin
                     emit            = 1'b1;
                     emit_rsp.status = ST_DESTROYED;
                     held_we         = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DEQ: begin
            if (out_free) begin
               emit                  = 1'b1;
               wc_en                 = 1'b1;
               emit_rsp.woken_valid  = 1'b1;
               emit_rsp.woken_thread = THREAD_W'(first_ff);
               if (cmd_op_ff == OP_UNLOCK) begin
                  emit_rsp.status = ST_HANDOFF;
                  lk_wr_en        = 1'b1;
                  lk_wr_data      = {first_ff, nw_rd_data, last_ff};
                  ne_we           = done;
                  state_in        = S_IDLE;
               end else begin
                  emit_rsp.status = ST_DESTROYED;
                  emit_rsp.last   = done;
                  if (done) begin
                     ne_we    = 1'b1;
                     held_we  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     first_we   = 1'b1;
                     nw_rd_en   = 1'b1;
                     nw_rd_addr = nw_rd_data;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) begin
            held_ff[i] <= 1'b0;
            ne_ff[i]   <= 1'b0;
         end
         for (int k = 0; k < NUM_THREADS; k++) begin
            waiting_ff[k] <= 1'b0;
         end
      end else begin
         if (held_we) begin
            held_ff[cmd_l_ff] <= held_in;
         end
         if (ne_we) begin
            ne_ff[cmd_l_ff] <= ne_in;
         end
         if (ws_en) begin
            waiting_ff[cmd_t_ff] <= 1'b1;
         end
         if (wc_en) begin
            waiting_ff[first_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         cmd_op_ff <= cmd_op;
         cmd_l_ff  <= cmd_lock;
         cmd_t_ff  <= cmd_thread;
      end
      if (load_fl) begin
         first_ff <= w_first;
         last_ff  <= w_last;
      end else if (first_we) begin
         first_ff <= first_in;
      end
      if (emit) begin
         rsp_ff <= emit_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `MLU_ASSERT_IMP(a_deq_nonempty, clock, reset, state_ff == S_DEQ, ne, "dequeue from empty queue")
   `MLU_ASSERT_IMP(a_head_waiting, clock, reset, state_ff == S_DEQ, waiting_ff[first_ff], "queue head not waiting")
   `MLU_ASSERT_IMP(a_handoff_held, clock, reset, state_ff == S_DEQ && cmd_op_ff == OP_UNLOCK, held, "handoff on free lock")
   `MLU_ASSERT_NXT(a_walk_ends, clock, reset, state_ff == S_DEQ && out_free && done, state_ff == S_IDLE, "walk did not stop at tail")

endmodule

`default_nettype wire
